### rtl/core/nrt_pkg.sv
package nrt_pkg;

  // Field widths
  localparam int SEQ_W     = 10;
  localparam int TOTAL_W   = 11;
  localparam int ID_W      = 8;
  localparam int KIND_W    = 3;

  // Bitmap word organisation
  localparam int WORD_W    = 32;
  localparam int BIT_W     = 5;
  localparam int WIDX_W    = SEQ_W - BIT_W;

  // Accepted traffic
  localparam logic [ID_W-1:0] PROTO_DATA = 8'd19;
  localparam logic [ID_W-1:0] NODE_SELF  = 8'd2;

  // Defaults
  localparam int                 DEF_MAX_PACKETS = 1024;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET     = 11'd1024;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_NEW          = 3'd0,
    KIND_DUP          = 3'd1,
    KIND_REJECT       = 3'd2,
    KIND_NAK          = 3'd3,
    KIND_NONE_MISSING = 3'd4,
    KIND_ALL_RECEIVED = 3'd5
  } kind_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PKT_RD,
    ST_PKT_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RESP
  } state_t;

  // Word scan result
  typedef struct packed {
    logic             found;
    logic [SEQ_W-1:0] pos;
    logic             exhausted;
  } gap_res_t;

endpackage

### rtl/core/nrt_ram.sv
module nrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/nrt_gap_find.sv
module nrt_gap_find (
  input  logic [nrt_pkg::WORD_W-1:0] word,
  input  logic [nrt_pkg::WIDX_W-1:0] word_idx,
  input  logic [nrt_pkg::BIT_W-1:0]  lo_bit,
  input  logic [nrt_pkg::SEQ_W-1:0]  highest,
  output nrt_pkg::gap_res_t          res
);
  import nrt_pkg::*;

  logic [WORD_W-1:0] cand;
  logic [WIDX_W-1:0] hi_word;
  logic [BIT_W-1:0]  hi_bit;
  logic [BIT_W-1:0]  bitpos;
  logic              found;
  logic [WIDX_W:0]   nxt_word;

  assign hi_word  = highest[SEQ_W-1:BIT_W];
  assign hi_bit   = highest[BIT_W-1:0];
  assign nxt_word = {1'b0, word_idx} + 1'b1;

  // Clear bits inside the window [lo_bit, highest)
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      cand[b] = ~word[b] && (BIT_W'(b) >= lo_bit) &&
                ((word_idx < hi_word) || ((word_idx == hi_word) && (BIT_W'(b) < hi_bit)));
    end
  end

  // Lowest candidate wins
  always_comb begin
    found  = 1'b0;
    bitpos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        found  = 1'b1;
        bitpos = BIT_W'(b);
      end
    end
  end

  assign res.found     = found;
  assign res.pos       = {word_idx, bitpos};
  // Next word starts at or past the limit: nothing left to scan
  assign res.exhausted = ({nxt_word, {BIT_W{1'b0}}} >= {1'b0, highest});

endmodule

### rtl/core/nak_receive_tracker.sv
// Item steps, acceptance to result: data packet decode, word read, check/update, respond;
//   rejected packet decode, respond; poll tick a read and a check per 32-bit bitmap word, then respond.
// The bitmap RAM has one read port and one write port; a single word scanner checks each polled word.
// One item at a time; a finished result waits in the output register while the next is taken.
// Reset (rst_n low, synchronous) clears all counters and sets total_packets to 1024, then a
//   clearing pass zeroes each of the ceil(MAX_PACKETS/32) bitmap words before the first item.
module nak_receive_tracker #(
  parameter int MAX_PACKETS = nrt_pkg::DEF_MAX_PACKETS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [nrt_pkg::TOTAL_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [nrt_pkg::ID_W-1:0]    in_protocol_id,
  input  logic [nrt_pkg::ID_W-1:0]    in_dest_id,
  input  logic [nrt_pkg::SEQ_W-1:0]   in_seq_num,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [nrt_pkg::KIND_W-1:0]  out_kind,
  output logic [nrt_pkg::SEQ_W-1:0]   out_nak_seq,
  output logic [nrt_pkg::TOTAL_W-1:0] out_count
);
  import nrt_pkg::*;

  localparam int MAP_WORDS = (MAX_PACKETS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic [TOTAL_W-1:0] total_pk_r, total_pk_nxt;
  logic [SEQ_W-1:0]   scan_start_r, scan_start_nxt;
  logic [SEQ_W-1:0]   highest_r, highest_nxt;
  logic [TOTAL_W-1:0] rcv_total_r, rcv_total_nxt;
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic [SEQ_W-1:0]   ptr_r, ptr_nxt;
  kind_t              res_kind_r, res_kind_nxt;
  logic [SEQ_W-1:0]   res_nak_r, res_nak_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [SEQ_W-1:0]   out_nak_r, out_nak_nxt;
  logic [TOTAL_W-1:0] out_count_r, out_count_nxt;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;
  gap_res_t           gap;
  logic               accept, reject, out_free;

  // Bitmap, one 32-bit word per row
  nrt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS),
    .AW    (ADDR_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Word scanner for poll ticks
  nrt_gap_find u_gap (
    .word     (ram_rdata),
    .word_idx (ptr_r[SEQ_W-1:BIT_W]),
    .lo_bit   (ptr_r[BIT_W-1:0]),
    .highest  (highest_r),
    .res      (gap)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign reject   = (in_protocol_id != PROTO_DATA) || (in_dest_id != NODE_SELF) ||
                    ({1'b0, in_seq_num} >= total_pk_r) ||
                    (32'(in_seq_num) >= 32'(MAX_PACKETS));

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      total_pk_r   <= TOTAL_RESET;
      scan_start_r <= '0;
      highest_r    <= '0;
      rcv_total_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      total_pk_r   <= total_pk_nxt;
      scan_start_r <= scan_start_nxt;
      highest_r    <= highest_nxt;
      rcv_total_r  <= rcv_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    seq_r       <= seq_nxt;
    ptr_r       <= ptr_nxt;
    res_kind_r  <= res_kind_nxt;
    res_nak_r   <= res_nak_nxt;
    out_kind_r  <= out_kind_nxt;
    out_nak_r   <= out_nak_nxt;
    out_count_r <= out_count_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    total_pk_nxt   = cfg_wr_en ? cfg_wr_data : total_pk_r;
    scan_start_nxt = scan_start_r;
    highest_nxt    = highest_r;
    rcv_total_nxt  = rcv_total_r;
    seq_nxt        = seq_r;
    ptr_nxt        = ptr_r;
    res_kind_nxt   = res_kind_r;
    res_nak_nxt    = res_nak_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_nak_nxt    = out_nak_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = ADDR_W'(seq_r[SEQ_W-1:BIT_W]);
    ram_wdata      = ram_rdata | (WORD_W'(1) << seq_r[BIT_W-1:0]);
    ram_re         = 1'b0;
    ram_raddr      = ADDR_W'(seq_r[SEQ_W-1:BIT_W]);

    unique case (state_r)
      // Zero the bitmap after reset
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r == ADDR_W'(MAP_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          seq_nxt     = in_seq_num;
          ptr_nxt     = scan_start_r;
          res_nak_nxt = '0;
          if (in_cmd) begin
            state_nxt = ST_SCAN_RD;
          end else if (reject) begin
            res_kind_nxt = KIND_REJECT;
            state_nxt    = ST_RESP;
          end else begin
            state_nxt = ST_PKT_RD;
          end
        end
      end

      ST_PKT_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_PKT_CHK;
      end

      // Test the bit, set it if new
      ST_PKT_CHK: begin
        if (ram_rdata[seq_r[BIT_W-1:0]]) begin
          res_kind_nxt = KIND_DUP;
        end else begin
          ram_we        = 1'b1;
          rcv_total_nxt = rcv_total_r + 1'b1;
          if (seq_r > highest_r) begin
            highest_nxt = seq_r;
          end
          res_kind_nxt = KIND_NEW;
        end
        state_nxt = ST_RESP;
      end

      ST_SCAN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(ptr_r[SEQ_W-1:BIT_W]);
        state_nxt = ST_SCAN_CHK;
      end

      // One word per pass through the scanner
      ST_SCAN_CHK: begin
        if (gap.found) begin
          res_kind_nxt = KIND_NAK;
          res_nak_nxt  = gap.pos;
          if (({1'b0, gap.pos} + 1'b1) == total_pk_r) begin
            scan_start_nxt = '0;
          end else begin
            scan_start_nxt = gap.pos + 1'b1;
          end
          state_nxt = ST_RESP;
        end else if (gap.exhausted) begin
          scan_start_nxt = '0;
          res_kind_nxt   = (rcv_total_r == total_pk_r) ? KIND_ALL_RECEIVED
                                                       : KIND_NONE_MISSING;
          state_nxt      = ST_RESP;
        end else begin
          ptr_nxt   = {ptr_r[SEQ_W-1:BIT_W] + 1'b1, {BIT_W{1'b0}}};
          state_nxt = ST_SCAN_RD;
        end
      end

      // Hand the result to the output register
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_nak_nxt   = res_nak_r;
          out_count_nxt = rcv_total_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_nak_seq = out_nak_r;
  assign out_count   = out_count_r;

endmodule
